// File: rtl/mbdpe_pkg.sv
// Shared constants and types for the debounced button press encoder.
`default_nettype none

package mbdpe_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int LEVEL_BITS  = 4;
    localparam int TIME_W      = 32;
    localparam int DELAY_W     = 16;
    localparam int ACTION_W    = 4;

    localparam logic [DELAY_W-1:0]  DELAY_RESET        = 16'd50;
    localparam logic [ACTION_W-1:0] ACT_NONE           = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_PRIMARY_BASE   = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SECONDARY_BASE = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_MAX            = 4'd8;

    // Per-lane update enables from the merge stage.
    typedef struct packed {
        logic commit;       // update change time and stable level
        logic commit_prev;  // also update the previous raw level
    } lane_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mbdpe_lane.sv
// One button lane: change tracking, elapsed time compare and stable level.
`default_nettype none

module mbdpe_lane (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          raw,
    input  wire logic [mbdpe_pkg::TIME_W-1:0]  now_ms,
    input  wire logic [mbdpe_pkg::DELAY_W-1:0] delay,
    input  wire mbdpe_pkg::lane_ctl_t          ctl,
    output logic                               press
);

    logic                         prev_reg;
    logic                         stable_reg;
    logic [mbdpe_pkg::TIME_W-1:0] ctime_reg;
    logic [mbdpe_pkg::TIME_W-1:0] ctime_next;
    logic [mbdpe_pkg::TIME_W-1:0] elapsed;
    logic                         take;

    always_comb
    begin
        ctime_next = (raw != prev_reg) ? now_ms : ctime_reg;
        elapsed    = now_ms - ctime_next;
        take       = (elapsed > {{(mbdpe_pkg::TIME_W-mbdpe_pkg::DELAY_W){1'b0}}, delay})
                     && (raw != stable_reg);
        press      = take && !raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b1;
            stable_reg <= 1'b1;
            ctime_reg  <= '0;
        end
        else
        begin
            if (ctl.commit)
            begin
                ctime_reg <= ctime_next;
                if (take)
                begin
                    stable_reg <= raw;
                end
            end
            if (ctl.commit_prev)
            begin
                prev_reg <= raw;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mbdpe_merge.sv
// Priority merge: first pressing lane picks the action and stops later lanes.
`default_nettype none

module mbdpe_merge (
    input  wire logic                                accept,
    input  wire logic                                func,
    input  wire logic [mbdpe_pkg::NUM_BUTTONS-1:0]   press,
    output mbdpe_pkg::lane_ctl_t                     ctl [mbdpe_pkg::NUM_BUTTONS],
    output logic [mbdpe_pkg::ACTION_W-1:0]           action_sel
);

    logic                              blocked;
    logic [mbdpe_pkg::ACTION_W-1:0]    base;

    always_comb
    begin
        blocked    = 1'b0;
        action_sel = mbdpe_pkg::ACT_NONE;
        base       = func ? mbdpe_pkg::ACT_SECONDARY_BASE : mbdpe_pkg::ACT_PRIMARY_BASE;
        for (int i = 0; i < mbdpe_pkg::NUM_BUTTONS; i++)
        begin
            ctl[i].commit      = accept && !blocked;
            ctl[i].commit_prev = accept && !blocked && !press[i];
            if (!blocked && press[i])
            begin
                action_sel = base + mbdpe_pkg::ACTION_W'(i);
            end
            blocked = blocked | press[i];
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_button_debounce_press_encoder_core.sv
// Top level of the debounced button press encoder.
// Usage:
//   Input channel (in_valid/in_stall) carries one sample item: func, the four
//   active-low button levels and the millisecond timestamp now_ms.
//   Output channel (out_valid/out_stall) returns exactly one action per item,
//   ACT_NONE when no new press was found.
//   The config channel (cfg_valid/cfg_ready) writes debounce_delay_ms; it is
//   always ready and should be written only while no item is in flight.
// Timing:
//   All button lanes evaluate in parallel and the merge picks the lowest
//   pressing button in the same cycle, so the action appears in the cycle after
//   the item is accepted. One item per cycle is sustained unless the receiver stalls.
//   The output register is the only buffering: when the receiver stalls with
//   a result held, in_stall rises in the same cycle until it is taken.
// Reset:
//   rst_n clears all buttons to released, change times to zero, the delay
//   to 50 ms and empties the output register.
`default_nettype none

module multi_button_debounce_press_encoder_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                func,
    input  wire logic [mbdpe_pkg::LEVEL_BITS-1:0]    button_levels,
    input  wire logic [mbdpe_pkg::TIME_W-1:0]        now_ms,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [mbdpe_pkg::ACTION_W-1:0]           action,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mbdpe_pkg::DELAY_W-1:0]       debounce_delay_ms
);

    logic                                  accept;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [mbdpe_pkg::ACTION_W-1:0]        action_reg;
    logic [mbdpe_pkg::ACTION_W-1:0]        action_sel;
    logic [mbdpe_pkg::DELAY_W-1:0]         delay_reg;
    logic [mbdpe_pkg::NUM_BUTTONS-1:0]     press;
    logic [mbdpe_pkg::NUM_BUTTONS-1:0]     commit_vec;
    logic [mbdpe_pkg::NUM_BUTTONS-1:0]     prev_vec;
    mbdpe_pkg::lane_ctl_t                  ctl [mbdpe_pkg::NUM_BUTTONS];

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    for (genvar g = 0; g < mbdpe_pkg::NUM_BUTTONS; g++)
    begin : g_lane
        logic raw;

        // Buttons beyond the sampled pins always read released.
        if (g < mbdpe_pkg::LEVEL_BITS)
        begin : g_pin
            assign raw = button_levels[g];
        end
        else
        begin : g_nopin
            assign raw = 1'b1;
        end

        assign commit_vec[g] = ctl[g].commit;
        assign prev_vec[g]   = ctl[g].commit_prev;

        mbdpe_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .raw    (raw),
            .now_ms (now_ms),
            .delay  (delay_reg),
            .ctl    (ctl[g]),
            .press  (press[g])
        );
    end

    mbdpe_merge u_merge (
        .accept     (accept),
        .func       (func),
        .press      (press),
        .ctl        (ctl),
        .action_sel (action_sel)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            delay_reg     <= mbdpe_pkg::DELAY_RESET;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                delay_reg <= debounce_delay_ms;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action_sel;
        end
    end

    // Every accepted item leaves a result in the output register.
    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted item produced no result");

    // Lane state only moves on an accepted item.
    a_commit_gated: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> (commit_vec == '0) && (prev_vec == '0))
        else $error("lane updated without an accepted item");

    // At most one lane stops the scan per item.
    a_single_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(commit_vec & ~prev_vec))
        else $error("more than one lane stopped the scan");

    // A held result is always a defined action code.
    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (action <= mbdpe_pkg::ACT_MAX))
        else $error("action code out of range");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the debounced button press encoder core.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic                             sel;
        logic [mbdpe_pkg::LEVEL_BITS-1:0] levels;
        logic [mbdpe_pkg::TIME_W-1:0]     stamp;
    } sample_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             func = 1'b0;
    logic [mbdpe_pkg::LEVEL_BITS-1:0] button_levels = '1;
    logic [mbdpe_pkg::TIME_W-1:0]     now_ms = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [mbdpe_pkg::ACTION_W-1:0]   action;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [mbdpe_pkg::DELAY_W-1:0]    debounce_delay_ms = '0;

    // Predictor state: a copy of the debounce state and of the delay register.
    logic [mbdpe_pkg::NUM_BUTTONS-1:0] last_raw = '1;
    logic [mbdpe_pkg::NUM_BUTTONS-1:0] stable_lvl = '1;
    logic [mbdpe_pkg::TIME_W-1:0]      chg_time [mbdpe_pkg::NUM_BUTTONS];
    logic [mbdpe_pkg::DELAY_W-1:0]     delay_model = mbdpe_pkg::DELAY_RESET;

    sample_t                        pending_samples [$];
    logic [mbdpe_pkg::ACTION_W-1:0] expected_actions [$];
    sample_t                        next_sample;

    int  items_queued = 0;
    int  items_accepted = 0;
    int  presses_seen = 0;
    int  fail_count = 0;
    int  cfg_writes = 0;
    int  in_gap = 0;
    int  rx_gap = 0;
    int  long_hold = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;
    bit  quiet = 1'b0;

    multi_button_debounce_press_encoder_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .func              (func),
        .button_levels     (button_levels),
        .now_ms            (now_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .action            (action),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .debounce_delay_ms (debounce_delay_ms)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Scan the buttons in index order; the first new press wins and stops the scan.
    function automatic logic [mbdpe_pkg::ACTION_W-1:0] encode_press(
        input logic                             sel,
        input logic [mbdpe_pkg::LEVEL_BITS-1:0] lv,
        input logic [mbdpe_pkg::TIME_W-1:0]     t);
        logic [mbdpe_pkg::TIME_W-1:0]   elapsed;
        logic [mbdpe_pkg::ACTION_W-1:0] base;
        logic                           raw;
        base = sel ? mbdpe_pkg::ACT_SECONDARY_BASE : mbdpe_pkg::ACT_PRIMARY_BASE;
        for (int i = 0; i < mbdpe_pkg::NUM_BUTTONS; i++)
        begin
            raw = (i < mbdpe_pkg::LEVEL_BITS) ? lv[i] : 1'b1;
            if (raw != last_raw[i])
                chg_time[i] = t;
            elapsed = t - chg_time[i];
            if (elapsed > delay_model && raw != stable_lvl[i])
            begin
                stable_lvl[i] = raw;
                if (!raw)
                    return base + mbdpe_pkg::ACTION_W'(i);
            end
            last_raw[i] = raw;
        end
        return mbdpe_pkg::ACT_NONE;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Time steps cluster around the debounce delay so that the strict compare is exercised.
    function automatic logic [mbdpe_pkg::TIME_W-1:0] pick_step(
        input logic [mbdpe_pkg::DELAY_W-1:0] d);
        logic [mbdpe_pkg::TIME_W-1:0] dl;
        int                           r;
        dl = mbdpe_pkg::TIME_W'(d);
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, dl / 4 + 1);
        if (r < 55)
            return dl;
        if (r < 70)
            return dl + 1;
        if (r < 80)
            return dl + $urandom_range(2, 200);
        if (r < 88)
            return $urandom_range(0, dl);
        if (r < 94)
            return '0;
        if (r < 97)
            return -mbdpe_pkg::TIME_W'($urandom_range(1, 1000));
        return $urandom;
    endfunction

    task automatic push_sample(input logic sel,
                               input logic [mbdpe_pkg::LEVEL_BITS-1:0] lv,
                               input logic [mbdpe_pkg::TIME_W-1:0] t);
        pending_samples.push_back('{sel: sel, levels: lv, stamp: t});
        items_queued++;
    endtask

    task automatic drain();
        while (items_accepted != items_queued || expected_actions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_delay(input logic [mbdpe_pkg::DELAY_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        debounce_delay_ms <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        delay_model = d;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Buttons follow an intended state that flips now and then, with bounce and noise on top.
    task automatic press_traffic(input int count, input logic [mbdpe_pkg::DELAY_W-1:0] d,
                                 inout logic [mbdpe_pkg::TIME_W-1:0] t,
                                 inout logic [mbdpe_pkg::LEVEL_BITS-1:0] held);
        logic [mbdpe_pkg::LEVEL_BITS-1:0] lv;
        int                               r;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 5) == 0)
                held[$urandom_range(0, mbdpe_pkg::LEVEL_BITS-1)] ^= 1'b1;
            lv = held;
            r = $urandom_range(0, 99);
            if (r < 12)
                lv[$urandom_range(0, mbdpe_pkg::LEVEL_BITS-1)] ^= 1'b1;
            else if (r < 17)
                lv = mbdpe_pkg::LEVEL_BITS'($urandom_range(0, 15));
            t = t + pick_step(d);
            push_sample(1'($urandom_range(0, 1)), lv, t);
        end
    endtask

    // Sender: a new item is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                next_sample = pending_samples.pop_front();
                in_valid <= 1'b1;
                func <= next_sample.sel;
                button_levels <= next_sample.levels;
                now_ms <= next_sample.stamp;
                in_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off so the input side backs up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold > 0)
            begin
                long_hold <= long_hold - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && items_accepted >= 80)
            begin
                hold_done <= 1'b1;
                long_hold <= 200;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                rx_gap <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        logic [mbdpe_pkg::ACTION_W-1:0] exp_action;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_actions.push_back(encode_press(func, button_levels, now_ms));
                items_accepted <= items_accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (action != mbdpe_pkg::ACT_NONE)
                    presses_seen++;
                if (expected_actions.size() == 0)
                begin
                    $error("action: no item pending, actual %0d", action);
                    fail_count++;
                end
                else
                begin
                    exp_action = expected_actions.pop_front();
                    if (action !== exp_action)
                    begin
                        $error("action: expected %0d, actual %0d", exp_action, action);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [mbdpe_pkg::TIME_W-1:0]     t;
        logic [mbdpe_pkg::LEVEL_BITS-1:0] held;
        logic [mbdpe_pkg::DELAY_W-1:0]    d;
        for (int i = 0; i < mbdpe_pkg::NUM_BUTTONS; i++)
            chg_time[i] = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset delay of 50 ms.
        push_sample(1'b0, 4'hF, 32'd0);
        push_sample(1'b0, 4'hE, 32'd100);
        push_sample(1'b0, 4'hE, 32'd150);           // elapsed equals the delay: no press
        push_sample(1'b0, 4'hE, 32'd151);           // one past the delay: start
        push_sample(1'b1, 4'h0, 32'd200);
        push_sample(1'b1, 4'h0, 32'd300);           // button 1 wins, later buttons wait
        push_sample(1'b1, 4'h0, 32'd300);
        push_sample(1'b1, 4'h0, 32'd300);
        push_sample(1'b0, 4'hF, 32'd400);
        push_sample(1'b0, 4'hF, 32'd451);
        push_sample(1'b0, 4'h0, 32'd500);
        push_sample(1'b0, 4'h0, 32'd600);
        push_sample(1'b0, 4'h0, 32'd600);
        push_sample(1'b0, 4'h0, 32'd600);
        push_sample(1'b0, 4'h0, 32'd600);
        push_sample(1'b0, 4'hF, 32'hFFFF_FFF0);
        push_sample(1'b0, 4'hF, 32'h0000_0030);     // time wrapped past zero
        push_sample(1'b0, 4'h7, 32'h0000_0030);
        push_sample(1'b0, 4'h7, 32'h0000_0010);     // time went backwards: huge difference
        push_sample(1'b1, 4'hF, 32'hFFFF_FFFF);
        push_sample(1'b1, 4'hF, 32'hFFFF_FFFF);
        t = 32'hFFFF_FFFF;
        held = 4'hF;

        press_traffic(150, mbdpe_pkg::DELAY_RESET, t, held);
        drain();

        quiet = 1'b1;
        write_delay(16'd0);
        press_traffic(110, 16'd0, t, held);
        drain();

        quiet = 1'b0;
        write_delay(16'hFFFF);
        press_traffic(110, 16'hFFFF, t, held);
        drain();

        d = mbdpe_pkg::DELAY_W'($urandom_range(1, 20));
        write_delay(d);
        press_traffic(110, d, t, held);
        drain();

        d = mbdpe_pkg::DELAY_W'($urandom_range(0, 65535));
        write_delay(d);
        press_traffic(110, d, t, held);
        drain();
        repeat (10) @(negedge clk);

        $display("Covered %0d button samples over %0d delay writes, %0d presses reported.",
                 items_accepted, cfg_writes, presses_seen);
        $display("Delays included 0, 65535, the reset value and random values.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mbdpe_pkg.sv
rtl/mbdpe_lane.sv
rtl/mbdpe_merge.sv
rtl/multi_button_debounce_press_encoder_core.sv
verif/tb_top.sv
